### rtl/core/eabv_pkg.sv
// eabv_pkg: shared types, constants and the output rounding helper for the
// Euler angle to basis vector pipeline. No dependencies.
`timescale 1ns / 1ps
package eabv_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int FRAC_BITS    = 15;
	localparam int CORDIC_STEPS = 30;
	localparam int FIELD_W      = 16;

	// CORDIC datapath widths: Q2.30 with guard bits, angle in 2^32 per turn
	localparam int XW = 34;
	localparam int ZW = 33;
	// rounded sine / cosine hold [-1.0, +1.0] at FRAC_BITS
	localparam int SCW = FRAC_BITS + 2;
	// full product width
	localparam int PW  = 2 * SCW;

	// stages: angle register, CORDIC steps, sin/cos rounding, four in the basis unit
	localparam int BASIS_STAGES = 4;
	localparam int PIPE_DEPTH   = CORDIC_STEPS + 2 + BASIS_STAGES;

	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

	localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic [FIELD_W-1:0] pitch_angle;
		logic [FIELD_W-1:0] yaw_angle;
		logic [FIELD_W-1:0] roll_angle;
	} angles_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] forward_x;
		logic signed [FIELD_W-1:0] forward_y;
		logic signed [FIELD_W-1:0] forward_z;
		logic signed [FIELD_W-1:0] right_x;
		logic signed [FIELD_W-1:0] right_y;
		logic signed [FIELD_W-1:0] right_z;
		logic signed [FIELD_W-1:0] up_x;
		logic signed [FIELD_W-1:0] up_y;
		logic signed [FIELD_W-1:0] up_z;
	} basis_t;

	// Q(2F) sum -> round half up, saturate to Q(F), keep the field bits
	function automatic logic [FIELD_W-1:0] finish(input logic signed [PW:0] v);
		logic signed [PW:0] r;
		logic signed [PW:0] half;
		logic signed [PW:0] hi;
		logic signed [PW:0] lo;
		half = (PW+1)'(1) <<< (FRAC_BITS - 1);
		hi   = ((PW+1)'(1) <<< FRAC_BITS) - (PW+1)'(1);
		lo   = -((PW+1)'(1) <<< FRAC_BITS);
		r    = (v + half) >>> FRAC_BITS;
		if (r > hi)
			r = hi;
		else if (r < lo)
			r = lo;
		return r[FIELD_W-1:0];
	endfunction

endpackage

### rtl/core/eabv_cordic.sv
// eabv_cordic: one sine/cosine lane, a register per CORDIC rotation step,
// then quadrant fold and rounding to Q(FRAC_BITS). Depends on eabv_pkg.
`timescale 1ns / 1ps
module eabv_cordic (
	input  logic                            clk,
	input  logic                            en,
	input  logic [eabv_pkg::FIELD_W-1:0]    angle,
	output logic signed [eabv_pkg::SCW-1:0] sin_val,
	output logic signed [eabv_pkg::SCW-1:0] cos_val
);
	import eabv_pkg::*;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam int SH = 30 - FRAC_BITS;

	logic [31:0]          th;
	logic [1:0]           q_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] x_s [1:CORDIC_STEPS];
	logic signed [XW-1:0] y_s [1:CORDIC_STEPS];

	// angle onto a 32-bit turn scale, top two bits are the quadrant
	assign th = 32'(angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= th[31:30];
			z_s[0] <= $signed({3'b000, th[29:0]});
		end
	end

	// one rotation step per stage
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic signed [XW-1:0] xsh;
		logic signed [XW-1:0] ysh;
		logic signed [ZW-1:0] at;

		if (k == 0) begin : g_first
			assign xi = $signed({2'b00, CORDIC_GAIN});
			assign yi = '0;
		end else begin : g_rest
			assign xi = x_s[k];
			assign yi = y_s[k];
		end

		assign xsh = xi >>> k;
		assign ysh = yi >>> k;
		assign at  = $signed({1'b0, ATAN_TURN32[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1] <= q_s[k];
				if (!z_s[k][ZW-1]) begin
					x_s[k+1] <= xi - ysh;
					y_s[k+1] <= yi + xsh;
					z_s[k+1] <= z_s[k] - at;
				end else begin
					x_s[k+1] <= xi + ysh;
					y_s[k+1] <= yi - xsh;
					z_s[k+1] <= z_s[k] + at;
				end
			end
		end
	end

	// quadrant fold
	logic signed [XW:0] xe, ye, c_raw, s_raw;
	assign xe = (XW+1)'(x_s[CORDIC_STEPS]);
	assign ye = (XW+1)'(y_s[CORDIC_STEPS]);

	always_comb begin
		case (q_s[CORDIC_STEPS])
			QUAD_I: begin
				c_raw = xe;
				s_raw = ye;
			end
			QUAD_II: begin
				c_raw = -ye;
				s_raw = xe;
			end
			QUAD_III: begin
				c_raw = -xe;
				s_raw = -ye;
			end
			default: begin
				c_raw = ye;
				s_raw = -xe;
			end
		endcase
	end

	function automatic logic signed [SCW-1:0] round_clamp(input logic signed [XW:0] v);
		logic signed [XW:0] r;
		logic signed [XW:0] one;
		one = (XW+1)'(1) <<< FRAC_BITS;
		r   = (v + ((XW+1)'(1) <<< (SH - 1))) >>> SH;
		if (r > one)
			r = one;
		else if (r < -one)
			r = -one;
		return r[SCW-1:0];
	endfunction

	// rounded sine / cosine register
	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= round_clamp(c_raw);
			sin_val <= round_clamp(s_raw);
		end
	end

endmodule

### rtl/core/eabv_basis.sv
// eabv_basis: four-stage product and sum pipeline that turns the six sines
// and cosines into the nine basis components. Depends on eabv_pkg.
`timescale 1ns / 1ps
module eabv_basis (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [eabv_pkg::SCW-1:0] sp,
	input  logic signed [eabv_pkg::SCW-1:0] cp,
	input  logic signed [eabv_pkg::SCW-1:0] sy,
	input  logic signed [eabv_pkg::SCW-1:0] cy,
	input  logic signed [eabv_pkg::SCW-1:0] sr,
	input  logic signed [eabv_pkg::SCW-1:0] cr,
	output eabv_pkg::basis_t                basis
);
	import eabv_pkg::*;

	// stage 1: two-term products
	logic signed [PW-1:0]  srsp_s1, crsp_s1;
	logic signed [PW-1:0]  cpcy_s1, cpsy_s1, crsy_s1, crcy_s1;
	logic signed [PW-1:0]  srcp_s1, srsy_s1, srcy_s1, crcp_s1;
	logic signed [SCW-1:0] sy_s1, cy_s1, sp_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s1 <= PW'(sr) * PW'(sp);
			crsp_s1 <= PW'(cr) * PW'(sp);
			cpcy_s1 <= PW'(cp) * PW'(cy);
			cpsy_s1 <= PW'(cp) * PW'(sy);
			crsy_s1 <= PW'(cr) * PW'(sy);
			crcy_s1 <= PW'(cr) * PW'(cy);
			srcp_s1 <= PW'(sr) * PW'(cp);
			srsy_s1 <= PW'(sr) * PW'(sy);
			srcy_s1 <= PW'(sr) * PW'(cy);
			crcp_s1 <= PW'(cr) * PW'(cp);
			sy_s1   <= sy;
			cy_s1   <= cy;
			sp_s1   <= sp;
		end
	end

	// stage 2: round sr*sp and cr*sp back to Q(F)
	logic signed [PW-1:0]  half;
	logic signed [PW-1:0]  srsp_r, crsp_r;
	logic signed [SCW-1:0] srsp_s2, crsp_s2;
	logic signed [PW-1:0]  cpcy_s2, cpsy_s2, crsy_s2, crcy_s2;
	logic signed [PW-1:0]  srcp_s2, srsy_s2, srcy_s2, crcp_s2;
	logic signed [SCW-1:0] sy_s2, cy_s2, sp_s2;

	assign half   = PW'(1) <<< (FRAC_BITS - 1);
	assign srsp_r = (srsp_s1 + half) >>> FRAC_BITS;
	assign crsp_r = (crsp_s1 + half) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s2 <= srsp_r[SCW-1:0];
			crsp_s2 <= crsp_r[SCW-1:0];
			cpcy_s2 <= cpcy_s1;
			cpsy_s2 <= cpsy_s1;
			crsy_s2 <= crsy_s1;
			crcy_s2 <= crcy_s1;
			srcp_s2 <= srcp_s1;
			srsy_s2 <= srsy_s1;
			srcy_s2 <= srcy_s1;
			crcp_s2 <= crcp_s1;
			sy_s2   <= sy_s1;
			cy_s2   <= cy_s1;
			sp_s2   <= sp_s1;
		end
	end

	// stage 3: triple products
	logic signed [PW-1:0]  srspcy_s3, srspsy_s3, crspcy_s3, crspsy_s3;
	logic signed [PW-1:0]  cpcy_s3, cpsy_s3, crsy_s3, crcy_s3;
	logic signed [PW-1:0]  srcp_s3, srsy_s3, srcy_s3, crcp_s3;
	logic signed [SCW-1:0] sp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			srspcy_s3 <= PW'(srsp_s2) * PW'(cy_s2);
			srspsy_s3 <= PW'(srsp_s2) * PW'(sy_s2);
			crspcy_s3 <= PW'(crsp_s2) * PW'(cy_s2);
			crspsy_s3 <= PW'(crsp_s2) * PW'(sy_s2);
			cpcy_s3   <= cpcy_s2;
			cpsy_s3   <= cpsy_s2;
			crsy_s3   <= crsy_s2;
			crcy_s3   <= crcy_s2;
			srcp_s3   <= srcp_s2;
			srsy_s3   <= srsy_s2;
			srcy_s3   <= srcy_s2;
			crcp_s3   <= crcp_s2;
			sp_s3     <= sp_s2;
		end
	end

	// stage 4: sums, rounding and saturation into the output register
	logic signed [PW:0] e_srspcy, e_srspsy, e_crspcy, e_crspsy;
	logic signed [PW:0] e_cpcy, e_cpsy, e_crsy, e_crcy, e_srcp, e_srsy, e_srcy, e_crcp;
	logic signed [PW:0] e_fz;

	assign e_srspcy = (PW+1)'(srspcy_s3);
	assign e_srspsy = (PW+1)'(srspsy_s3);
	assign e_crspcy = (PW+1)'(crspcy_s3);
	assign e_crspsy = (PW+1)'(crspsy_s3);
	assign e_cpcy   = (PW+1)'(cpcy_s3);
	assign e_cpsy   = (PW+1)'(cpsy_s3);
	assign e_crsy   = (PW+1)'(crsy_s3);
	assign e_crcy   = (PW+1)'(crcy_s3);
	assign e_srcp   = (PW+1)'(srcp_s3);
	assign e_srsy   = (PW+1)'(srsy_s3);
	assign e_srcy   = (PW+1)'(srcy_s3);
	assign e_crcp   = (PW+1)'(crcp_s3);
	assign e_fz     = -((PW+1)'(sp_s3) <<< FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			basis.forward_x <= finish(e_cpcy);
			basis.forward_y <= finish(e_cpsy);
			basis.forward_z <= finish(e_fz);
			basis.right_x   <= finish(e_crsy - e_srspcy);
			basis.right_y   <= finish(-e_srspsy - e_crcy);
			basis.right_z   <= finish(-e_srcp);
			basis.up_x      <= finish(e_crspcy + e_srsy);
			basis.up_y      <= finish(e_crspsy - e_srcy);
			basis.up_z      <= finish(e_crcp);
		end
	end

endmodule

### rtl/core/euler_angles_to_basis_vectors.sv
// euler_angles_to_basis_vectors: top level, three CORDIC lanes feeding the
// basis product pipeline. Depends on eabv_pkg, eabv_cordic, eabv_basis.
//
//   channel  | direction | payload          | handshake
//   angles   | in        | eabv_pkg::angles_t | angles_valid / angles_ready
//   basis    | out       | eabv_pkg::basis_t  | basis_valid / basis_ready
//
// One request is taken every cycle while the output does not stall; each one
// passes one angle register, 30 CORDIC step registers, one sin/cos rounding
// register and four product and sum registers.
// Reset clears only the valid chain; payload registers are not reset.
// A stall at the output freezes the whole pipeline; angles_ready is low only
// while a result waits and basis_ready is low.
`timescale 1ns / 1ps
module euler_angles_to_basis_vectors (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              angles_valid,
	output logic              angles_ready,
	input  eabv_pkg::angles_t angles,
	output logic              basis_valid,
	input  logic              basis_ready,
	output eabv_pkg::basis_t  basis
);
	import eabv_pkg::*;

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic signed [SCW-1:0] sp, cp, sy, cy, sr, cr;

	// pipeline advances unless a finished result is held up
	assign en           = !vld_q[PIPE_DEPTH-1] || basis_ready;
	assign angles_ready = en;
	assign basis_valid  = vld_q[PIPE_DEPTH-1];

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], angles_valid};
		end
	end

	eabv_cordic u_pitch (
		.clk     (clk),
		.en      (en),
		.angle   (angles.pitch_angle),
		.sin_val (sp),
		.cos_val (cp)
	);

	eabv_cordic u_yaw (
		.clk     (clk),
		.en      (en),
		.angle   (angles.yaw_angle),
		.sin_val (sy),
		.cos_val (cy)
	);

	eabv_cordic u_roll (
		.clk     (clk),
		.en      (en),
		.angle   (angles.roll_angle),
		.sin_val (sr),
		.cos_val (cr)
	);

	eabv_basis u_basis (
		.clk   (clk),
		.en    (en),
		.sp    (sp),
		.cp    (cp),
		.sy    (sy),
		.cy    (cy),
		.sr    (sr),
		.cr    (cr),
		.basis (basis)
	);

endmodule

### rtl/core/eabv_checker.sv
// eabv_checker: port-level checks on the top level, attached by bind.
// Depends on eabv_pkg and euler_angles_to_basis_vectors.
`timescale 1ns / 1ps
module eabv_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             angles_ready,
	input logic             basis_valid,
	input logic             basis_ready,
	input eabv_pkg::basis_t basis
);
	import eabv_pkg::*;

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && !basis_ready |=> basis_valid && $stable(basis))
		else $error("basis result changed while stalled");

	// input side is blocked exactly when a result is stuck
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		angles_ready == (!basis_valid || basis_ready))
		else $error("angles_ready does not follow output stall");

	// an empty output never blocks a request
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!basis_valid |-> angles_ready)
		else $error("request refused with empty output");

	// a result only leaves through a handshake
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(basis_valid) |-> $past(basis_ready))
		else $error("basis_valid dropped without acceptance");

endmodule

bind euler_angles_to_basis_vectors eabv_checker u_eabv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.angles_ready (angles_ready),
	.basis_valid  (basis_valid),
	.basis_ready  (basis_ready),
	.basis        (basis)
);
